// ----- design/srt_fdt_pkg.sv -----
// Package with shared types and constants for the SRT truncating float divider.
package srt_fdt_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    DIG_ZERO = 2'b00,
    DIG_POS  = 2'b01,
    DIG_NEG  = 2'b10
  } digit_t;

  typedef struct packed {
    logic [WORD_W-1:0] rs;
    logic [WORD_W-1:0] rc;
    logic [WORD_W-1:0] q;
    logic [WORD_W-1:0] bm;
    digit_t            d;
    logic              sign;
    logic [7:0]        ea;
    logic [7:0]        eb;
  } stage_t;

  // Quotient digit selection from the carry-save estimate.
  function automatic digit_t pick_digit(input logic [WORD_W-1:0] s,
                                        input logic [WORD_W-1:0] c);
    logic [WORD_W-1:0] t;
    begin
      t = (({s[31:24], 24'h0}) + c) | {8'h0, s[23:0]};
      if (!t[31] && (t >= 32'h0080_0000)) begin
        pick_digit = DIG_POS;
      end else if (t[31] && (t < 32'hff00_0000)) begin
        pick_digit = DIG_NEG;
      end else begin
        pick_digit = DIG_ZERO;
      end
    end
  endfunction

  // One SRT step on a carry-save remainder.
  function automatic stage_t srt_step(input stage_t x);
    stage_t            y;
    logic [WORD_W-1:0] add;
    logic [WORD_W-1:0] rc;
    logic [WORD_W-1:0] ns;
    logic [WORD_W-1:0] nc;
    begin
      y = x;
      rc = x.rc;
      case (x.d)
        DIG_POS: begin
          y.q = (x.q << 1) + 32'd1;
          add = ~x.bm;
          rc = x.rc + 32'd1;
        end
        DIG_NEG: begin
          y.q = (x.q << 1) - 32'd1;
          add = x.bm;
        end
        default: begin
          y.q = x.q << 1;
          add = '0;
        end
      endcase
      ns = x.rs ^ rc ^ add;
      nc = ((x.rs & rc) | (x.rs & add) | (rc & add)) << 1;
      if (x.d != DIG_ZERO) begin
        y.d = pick_digit(ns, nc);
      end else begin
        y.d = pick_digit(x.rs, rc);
      end
      y.rs = ns << 1;
      y.rc = nc << 1;
      srt_step = y;
    end
  endfunction

endpackage

// ----- design/srt_float_divide_truncating_top.sv -----
// Top level of the pipelined SRT radix-2 truncating single-precision divider.
// Pipeline: input register, one stage per SRT step, output register.
// Throughput: one request per cycle while the pipeline is not stalled; each SRT step has its own register stage.
// The whole pipeline stalls together when the output is held and a result waits.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
module srt_float_divide_truncating_top #(
  parameter int unsigned SRT_STEPS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] dividend, [63:32] divisor
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] quotient_bits
);
  import srt_fdt_pkg::*;

  // The pipeline advances when the output slot is free or being emptied.
  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  logic   vld0_r;
  stage_t st0_r;
  logic   [SRT_STEPS:0] vld;
  stage_t stg [SRT_STEPS+1];

  // Input register: unpack operands and set up the initial remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0_r.rs   <= {7'd0, 1'b1, in_tdata[22:0], 1'b0} << 1;
      st0_r.rc   <= '0;
      st0_r.q    <= '0;
      st0_r.bm   <= {7'd0, 1'b1, in_tdata[54:32], 1'b0} << 1;
      st0_r.d    <= DIG_POS;
      st0_r.sign <= in_tdata[31] ^ in_tdata[63];
      st0_r.ea   <= in_tdata[30:23];
      st0_r.eb   <= in_tdata[62:55];
    end
  end

  assign vld[0] = vld0_r;
  assign stg[0] = st0_r;

  for (genvar g = 0; g < SRT_STEPS; g++) begin : g_step
    srt_fdt_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld[g]),
      .dat_in  (stg[g]),
      .vld_out (vld[g+1]),
      .dat_out (stg[g+1])
    );
  end

  // Normalization, exponent and special cases.
  stage_t      fin;
  logic [9:0]  e;
  logic [31:0] qn;
  logic [31:0] res;
  assign fin = stg[SRT_STEPS];

  always_comb begin
    e  = {2'b00, fin.ea} - {2'b00, fin.eb} + 10'd126;
    qn = fin.q;
    if (fin.q >= 32'h0100_0000) begin
      e  = e + 10'd1;
      qn = fin.q >> 1;
    end
    // e is signed in 10 bits: overflow means positive and above 255.
    if (fin.eb == 8'd0 || (!e[9] && e > 10'd255)) begin
      res = {fin.sign, 31'h7fff_ffff};
    end else if (fin.ea == 8'd0 || e[9] || e == 10'd0) begin
      res = {fin.sign, 31'd0};
    end else begin
      res = {fin.sign, e[7:0], qn[22:0]};
    end
  end

  logic        out_vld_r;
  logic [31:0] out_dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld[SRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dat_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow pipeline enable");
  a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld[SRT_STEPS] |=> out_tvalid)
    else $error("valid request lost at the output");
`endif
endmodule

// ----- design/srt_fdt_stage.sv -----
// One registered pipeline stage holding a single SRT iteration.
module srt_fdt_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  srt_fdt_pkg::stage_t dat_in,
  output logic                vld_out,
  output srt_fdt_pkg::stage_t dat_out
);
  import srt_fdt_pkg::*;

  logic   vld_r;
  stage_t dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= srt_step(dat_in);
    end
  end

  assign vld_out = vld_r;
  assign dat_out = dat_r;
endmodule
